// File: hw/rtl/pss_pkg.sv
// Shared types and constants of the PID steering speed scheduler.
package pss_pkg;

  // Width of the divider dividend and of its quotient.
  localparam int unsigned DivW  = 41;
  localparam int unsigned QuoW  = 26;

  // 180/pi in Q16.
  localparam logic [23:0] DegPerRadQ16 = 24'd3754937;
  localparam logic [37:0] ErrRound     = 38'd524288;

  // Integral and effort limits, Q8 degrees.
  localparam logic signed [23:0] IntegLimit  = 24'sd51200;
  localparam logic [23:0]        EffortSlow  = 24'd10240;
  localparam logic [23:0]        EffortReset = 24'd12800;
  localparam logic [23:0]        EffortPosMax = 24'd8388607;
  localparam logic [23:0]        EffortNegMax = 24'd8388608;

  // Gain scale factors applied when a tuning register is written.
  localparam logic [22:0] KpScale = 23'd80;
  localparam logic [22:0] KiScale = 23'd68;
  localparam logic [20:0] KdScale = 21'd17;

  // Rounding offsets added to the dividends, half of each divisor.
  localparam logic [DivW-1:0] PidRound   = 41'd17408000;
  localparam logic [DivW-1:0] SpeedRound = 41'd5120;

  // The divisor 34816000 is 2^14 * 2125 and 10240 is 2^11 * 5. Each quotient is a
  // right shift followed by a multiply with the scaled reciprocal of the odd part,
  // which is exact over the whole reachable dividend range.
  localparam int unsigned RecipNW        = 27;
  localparam int unsigned RecipW         = 29;
  localparam int unsigned PidPreShift    = 14;
  localparam int unsigned PidPostShift   = 40;
  localparam int unsigned SpeedPreShift  = 11;
  localparam int unsigned SpeedPostShift = 21;
  localparam logic [RecipW-1:0] PidRecip   = 29'd517417237;
  localparam logic [RecipW-1:0] SpeedRecip = 29'd419431;

  typedef enum logic [1:0] {
    REG_ULTIMATE_GAIN      = 2'd0,
    REG_OSCILLATION_PERIOD = 2'd1,
    REG_MIN_SPEED          = 2'd2,
    REG_MAX_SPEED          = 2'd3
  } pss_reg_t;

  typedef struct packed {
    logic            start;
    logic            pid_sel;
    logic [DivW-1:0] dividend;
  } pss_div_cmd_t;

  typedef struct packed {
    logic            done;
    logic [QuoW-1:0] quotient;
  } pss_div_rsp_t;

endpackage

// File: hw/rtl/pid_steer_speed_scheduler_core.sv
// Top level of the PID steering speed scheduler: sequencer, shared multiplier, divider.
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------------------------------
//   input    | in_valid / in_ready  | turn_rate_rad
//   output   | out_valid / out_ready| steer_deg, speed_out, control_effort
//   config   | cfg_wr_en            | cfg_addr, cfg_data
//
// An item makes one pass through the divider for u, and a second pass for the speed
// when |u| is under 40 degrees and the speed is scaled; in_ready rises with out_valid.
// The sequencer steps through the multiply and sum states, then the divider for u
// and, when the speed is scaled, the divider again for the speed.
// Reset is synchronous and clears the tuning registers, out_valid, the integral and the previous error.
// A finished result waits in the output register while the next item is taken.
module pid_steer_speed_scheduler_core
  import pss_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] turn_rate_rad,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [17:0] steer_deg,
  output logic        [15:0] speed_out,
  output logic signed [23:0] control_effort,
  input  logic               cfg_wr_en,
  input  logic         [1:0] cfg_addr,
  input  logic        [15:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_MULERR, S_ERR, S_MULP, S_MULI, S_MULD, S_SUM, S_DIVABS,
    S_DIVSET, S_UDIV, S_UFIN, S_SCHED, S_SPDSET, S_SDIV, S_DONE
  } state_t;

  state_t state;

  // Tuning registers, held as scaled gains.
  logic [22:0] kp_coef;
  logic [22:0] ki_coef;
  logic [20:0] kd_coef;
  logic [15:0] min_speed;
  logic [15:0] max_speed;

  logic        [16:0] xmag;
  logic               x_neg;
  logic signed [47:0] prod;
  logic signed [51:0] acc;
  logic               u_neg;
  logic signed [17:0] err;
  logic signed [18:0] diff;
  logic signed [17:0] prev_err;
  logic signed [23:0] integ;
  logic signed [23:0] effort;
  logic        [23:0] effort_mag;
  logic        [15:0] speed;

  logic signed [23:0] mul_a;
  logic signed [23:0] mul_b;
  logic        [37:0] err_sum;
  logic        [17:0] err_q;
  logic signed [17:0] err_new;
  logic signed [23:0] integ_base;
  logic        [QuoW-1:0] qmag;

  pss_div_cmd_t div_cmd;
  pss_div_rsp_t div_rsp;

  pss_div u_div (
    .clk (clk),
    .rst (rst),
    .cmd (div_cmd),
    .rsp (div_rsp)
  );

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      kp_coef   <= '0;
      ki_coef   <= '0;
      kd_coef   <= '0;
      min_speed <= '0;
      max_speed <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_ULTIMATE_GAIN:      kp_coef <= 23'(cfg_data) * KpScale;
        REG_OSCILLATION_PERIOD: begin
          ki_coef <= 23'(cfg_data) * KiScale;
          kd_coef <= 21'(cfg_data) * KdScale;
        end
        REG_MIN_SPEED:          min_speed <= cfg_data;
        REG_MAX_SPEED:          max_speed <= cfg_data;
      endcase
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (state)
      S_MULERR: begin
        mul_a = DegPerRadQ16;
        mul_b = 24'(xmag);
      end
      S_MULP: begin
        mul_a = 24'(kp_coef);
        mul_b = 24'(err);
      end
      S_MULI: begin
        mul_a = 24'(ki_coef);
        mul_b = integ;
      end
      S_MULD: begin
        mul_a = 24'(kd_coef);
        mul_b = 24'(diff);
      end
      S_SCHED: begin
        mul_a = 24'(max_speed);
        mul_b = EffortSlow - effort_mag;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // The error is the negated, rounded degree value of the command.
  assign err_sum    = prod[37:0] + ErrRound;
  assign err_q      = err_sum[37:20];
  assign err_new    = x_neg ? $signed(err_q) : -$signed(err_q);
  assign integ_base = (integ > IntegLimit || integ < -IntegLimit) ? '0 : integ;
  assign qmag       = div_rsp.quotient;

  always_comb begin
    div_cmd.start   = (state == S_DIVSET) || (state == S_SPDSET);
    div_cmd.pid_sel = (state == S_DIVSET);
    if (state == S_DIVSET) begin
      div_cmd.dividend = acc[DivW-1:0] + PidRound;
    end else begin
      div_cmd.dividend = prod[DivW-1:0] + SpeedRound;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      integ     <= '0;
      prev_err  <= '0;
    end else begin
      // A result loaded in S_DONE keeps out_valid high over a transfer in the same cycle.
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            x_neg <= turn_rate_rad[15];
            xmag  <= turn_rate_rad[15] ? 17'(-17'(turn_rate_rad)) : 17'(turn_rate_rad);
            state <= S_MULERR;
          end
        end
        S_MULERR: state <= S_ERR;
        S_ERR: begin
          err      <= err_new;
          diff     <= 19'(err_new) - 19'(prev_err);
          prev_err <= err_new;
          integ    <= integ_base + 24'(err_new);
          state    <= S_MULP;
        end
        S_MULP: state <= S_MULI;
        S_MULI: begin
          acc   <= 52'(prod);
          state <= S_MULD;
        end
        S_MULD: begin
          acc   <= acc + 52'(prod);
          state <= S_SUM;
        end
        S_SUM: begin
          acc   <= acc + 52'(prod);
          state <= S_DIVABS;
        end
        S_DIVABS: begin
          // Divide the magnitude and put the sign back afterwards.
          u_neg <= acc[51];
          acc   <= acc[51] ? -acc : acc;
          state <= S_DIVSET;
        end
        S_DIVSET: state <= S_UDIV;
        S_UDIV: begin
          if (div_rsp.done) begin
            state <= S_UFIN;
          end
        end
        S_UFIN: begin
          if (u_neg) begin
            if (qmag >= 26'(EffortNegMax)) begin
              effort     <= $signed(EffortNegMax);
              effort_mag <= EffortNegMax;
            end else begin
              effort     <= -$signed(qmag[23:0]);
              effort_mag <= qmag[23:0];
            end
          end else begin
            if (qmag > 26'(EffortPosMax)) begin
              effort     <= $signed(EffortPosMax);
              effort_mag <= EffortPosMax;
            end else begin
              effort     <= $signed(qmag[23:0]);
              effort_mag <= qmag[23:0];
            end
          end
          state <= S_SCHED;
        end
        S_SCHED: begin
          if (effort_mag < EffortSlow) begin
            state <= S_SPDSET;
          end else begin
            speed <= min_speed;
            if (effort_mag > EffortReset) begin
              integ <= '0;
            end
            state <= S_DONE;
          end
        end
        S_SPDSET: state <= S_SDIV;
        S_SDIV: begin
          if (div_rsp.done) begin
            speed <= qmag[15:0];
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            steer_deg      <= err;
            speed_out      <= speed;
            control_effort <= effort;
            out_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_div_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_UDIV || state == S_SDIV))
    else $error("divider finished while the sequencer was not waiting");

  a_integ_bounded: assert property (@(posedge clk) disable iff (rst)
    (integ <= 24'sd168542 && integ >= -24'sd168542))
    else $error("integral sum left its reachable range");

  a_effort_mag: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCHED) |-> ((effort[23] ? 24'(-effort) : 24'(effort)) == effort_mag))
    else $error("effort magnitude does not match the signed effort");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!out_valid || out_ready)) |=> (out_valid && state == S_IDLE))
    else $error("finished result was not presented");
`endif

endmodule

// File: hw/rtl/pss_div.sv
// Constant divider by reciprocal multiplication; registers num, then prod and done.
module pss_div
  import pss_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  pss_div_cmd_t cmd,
  output pss_div_rsp_t rsp
);

  logic                      busy;
  logic                      done;
  logic                      pid_sel;
  logic [RecipNW-1:0]        num;
  logic [RecipW-1:0]         recip;
  logic [RecipNW+RecipW-1:0] prod;

  assign recip = pid_sel ? PidRecip : SpeedRecip;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy    <= 1'b1;
        pid_sel <= cmd.pid_sel;
        num     <= cmd.pid_sel ? RecipNW'(cmd.dividend >> PidPreShift)
                               : RecipNW'(cmd.dividend >> SpeedPreShift);
      end else if (busy) begin
        prod <= num * recip;
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = pid_sel ? QuoW'(prod >> PidPostShift)
                                : QuoW'(prod >> SpeedPostShift);

endmodule

// File: tb/tb_top.sv
// Self-checking testbench of the PID steering speed scheduler core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pss_pkg::*;

  localparam longint RadToDegQ16 = 3754937;
  localparam longint ErrShift    = 64'sd1 << 20;
  localparam longint IntegClear  = 200 * 256;
  localparam longint SlowLimit   = 40 * 256;
  localparam longint ClearLimit  = 50 * 256;
  localparam longint PidDen      = 34816000;
  localparam longint UMax        = 8388607;
  localparam longint UMin        = -8388608;
  localparam int     MaxReports  = 200;

  typedef struct packed {
    logic signed [17:0] steer;
    logic        [15:0] speed;
    logic signed [23:0] effort;
  } steer_cmd_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] turn_rate_rad = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [17:0] steer_deg;
  logic        [15:0] speed_out;
  logic signed [23:0] control_effort;
  logic               cfg_wr_en = 1'b0;
  logic         [1:0] cfg_addr = '0;
  logic        [15:0] cfg_data = '0;

  // Predictor state: tuning registers, integral and previous error.
  logic [15:0] ku_reg, pu_reg, min_speed_reg, max_speed_reg;
  longint      integ_sum, prev_err;

  steer_cmd_t  steer_cmd_q[$];
  int          error_count = 0;
  int          report_count = 0;
  bit          in_idle_on = 1'b0;
  bit          out_stall_on = 1'b0;

  pid_steer_speed_scheduler_core i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .turn_rate_rad  (turn_rate_rad),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .steer_deg      (steer_deg),
    .speed_out      (speed_out),
    .control_effort (control_effort),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_addr       (cfg_addr),
    .cfg_data       (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic longint round_div(input longint num, input longint den);
    longint mag;
    mag = (num < 0) ? -num : num;
    mag = (mag + den / 2) / den;
    return (num < 0) ? -mag : mag;
  endfunction

  // Advances the integral and previous error by one command and returns the outputs.
  function automatic steer_cmd_t pid_update(input logic signed [15:0] rate);
    steer_cmd_t r;
    longint x, err, num, u, au, spd, ku, pu, vmax;
    x    = rate;
    ku   = ku_reg;
    pu   = pu_reg;
    vmax = max_speed_reg;
    err  = -round_div(x * RadToDegQ16, ErrShift);
    if (((integ_sum < 0) ? -integ_sum : integ_sum) > IntegClear) integ_sum = 0;
    integ_sum = integ_sum + err;
    num = 80 * ku * err + 68 * pu * integ_sum + 17 * pu * (err - prev_err);
    u = round_div(num, PidDen);
    if (u > UMax) u = UMax;
    if (u < UMin) u = UMin;
    au = (u < 0) ? -u : u;
    if (au < SlowLimit) begin
      spd = (vmax * (SlowLimit - au) + SlowLimit / 2) / SlowLimit;
    end else begin
      spd = min_speed_reg;
      if (au > ClearLimit) integ_sum = 0;
    end
    prev_err = err;
    r.steer  = err[17:0];
    r.speed  = spd[15:0];
    r.effort = u[23:0];
    return r;
  endfunction

  function automatic logic [15:0] pick_setting();
    logic [15:0] v;
    case ($urandom_range(0, 3))
      0:       v = 16'h0000;
      1:       v = 16'hFFFF;
      2:       v = 16'($urandom_range(0, 65535));
      default: v = 16'($urandom_range(0, 2047));
    endcase
    return v;
  endfunction

  // Sends one turn-rate command and records its expected result on the transfer.
  task automatic send_rate(input logic signed [15:0] rate);
    int gap;
    gap = in_idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    turn_rate_rad <= rate;
    do @(posedge clk); while (in_ready !== 1'b1);
    steer_cmd_q.push_back(pid_update(rate));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (steer_cmd_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input pss_reg_t idx, input logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_ULTIMATE_GAIN:      ku_reg = val;
      REG_OSCILLATION_PERIOD: pu_reg = val;
      REG_MIN_SPEED:          min_speed_reg = val;
      REG_MAX_SPEED:          max_speed_reg = val;
      default: ;
    endcase
  endtask

  task automatic tune(input logic [15:0] ku, input logic [15:0] pu,
                      input logic [15:0] vmin, input logic [15:0] vmax);
    wait_idle();
    write_reg(REG_ULTIMATE_GAIN, ku);
    write_reg(REG_OSCILLATION_PERIOD, pu);
    write_reg(REG_MIN_SPEED, vmin);
    write_reg(REG_MAX_SPEED, vmax);
    cfg_wr_en <= 1'b0;
  endtask

  // With every register at reset the effort is zero and so is the speed.
  task automatic test_reset_values();
    send_rate(16'sd0);
    send_rate(16'sh7FFF);
    send_rate(-16'sh8000);
    send_rate(16'sd1);
    send_rate(-16'sd1);
  endtask

  // Zero gains leave the effort at zero, so the full speed comes out.
  task automatic test_zero_gains();
    tune(16'h0000, 16'h0000, 16'h1234, 16'hFFFF);
    send_rate(16'sd100);
    send_rate(-16'sd100);
  endtask

  // Full gains drive the effort past both limits: minimum speed and integral clears.
  task automatic test_large_effort();
    tune(16'hFFFF, 16'hFFFF, 16'h0100, 16'hFFFF);
    repeat (3) send_rate(-16'sh8000);
    send_rate(16'sh7FFF);
    send_rate(16'sh7FFF);
    send_rate(16'sd0);
    send_rate(16'sd0);
    send_rate(16'sd1);
    send_rate(-16'sd1);
  endtask

  // Moderate gains keep the effort small, so the speed is scaled down from the maximum.
  task automatic test_scaled_speed();
    tune(16'h0800, 16'h0100, 16'h0000, 16'h8000);
    send_rate(16'sd4096);
    send_rate(-16'sd4096);
    send_rate(16'sd8192);
    repeat (3) send_rate(16'sd20000);
  endtask

  // Random phases: full-range, small and extreme commands mixed with same-sign runs.
  task automatic test_random(input int phases, input int per_phase);
    int sent, run_len, pick;
    logic signed [15:0] rate;
    logic [15:0] mag;
    bit neg;
    for (int p = 0; p < phases; p++) begin
      if (p == 1) tune(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      else if (p == 2) tune(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      else tune(pick_setting(), pick_setting(), pick_setting(), pick_setting());
      in_idle_on   = (p == 0) ? 1'b0 : 1'($urandom_range(0, 1));
      out_stall_on = (p == 0) ? 1'b0 : 1'($urandom_range(0, 1));
      sent = 0;
      while (sent < per_phase) begin
        pick = $urandom_range(0, 9);
        if (pick <= 3) begin
          rate = 16'($urandom_range(0, 65535));
          send_rate(rate);
          sent++;
        end else if (pick <= 6) begin
          rate = 16'($urandom_range(0, 2047) - 1024);
          send_rate(rate);
          sent++;
        end else if (pick == 7) begin
          case ($urandom_range(0, 4))
            0:       rate = 16'sh7FFF;
            1:       rate = -16'sh8000;
            2:       rate = 16'sd1;
            3:       rate = -16'sd1;
            default: rate = 16'sd0;
          endcase
          send_rate(rate);
          sent++;
        end else begin
          // A run of same-sign commands winds the integral up toward its clear limit.
          run_len = $urandom_range(3, 8);
          neg = 1'($urandom_range(0, 1));
          for (int k = 0; k < run_len; k++) begin
            mag  = 16'($urandom_range(0, 32767));
            rate = neg ? -$signed(mag) : $signed(mag);
            send_rate(rate);
          end
          sent += run_len;
        end
      end
    end
  endtask

  initial begin
    ku_reg = '0;
    pu_reg = '0;
    min_speed_reg = '0;
    max_speed_reg = '0;
    integ_sum = 0;
    prev_err = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_zero_gains();
    test_large_effort();
    test_scaled_speed();
    test_random(8, 81);
    wait_idle();
    repeat (64) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Takes each result transfer and compares it with the oldest expected command.
  initial begin : result_check
    steer_cmd_t exp_cmd;
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = out_stall_on ? $urandom_range(0, 5) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (steer_cmd_q.size() == 0) begin
        error_count++;
        if (report_count++ < MaxReports)
          $display("%0t: unexpected result, steer %0d speed %0d effort %0d",
                   $time, steer_deg, speed_out, control_effort);
      end else begin
        exp_cmd = steer_cmd_q.pop_front();
        if (steer_deg !== exp_cmd.steer) begin
          error_count++;
          if (report_count++ < MaxReports)
            $display("%0t: steer_deg expected %0d, got %0d",
                     $time, exp_cmd.steer, steer_deg);
        end
        if (speed_out !== exp_cmd.speed) begin
          error_count++;
          if (report_count++ < MaxReports)
            $display("%0t: speed_out expected %0d, got %0d",
                     $time, exp_cmd.speed, speed_out);
        end
        if (control_effort !== exp_cmd.effort) begin
          error_count++;
          if (report_count++ < MaxReports)
            $display("%0t: control_effort expected %0d, got %0d",
                     $time, exp_cmd.effort, control_effort);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
